// ===== hdl/relay_self_test_sequencer_top_macros.svh =====
// assertion macros shared by the relay self test checker
`ifndef RELAY_SELF_TEST_SEQUENCER_TOP_MACROS_SVH
`define RELAY_SELF_TEST_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define RSTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsts check failed");

// next-cycle implication, checked outside reset
`define RSTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsts check failed");

`endif

// ===== hdl/rsts_pkg.sv =====
// shared types and codes of the relay self test sequencer
package rsts_pkg;

  localparam int TimeoutW = 16;
  localparam int MinPollsW = 8;
  localparam int CfgDataW = 16;
  localparam int InDataW = 40;
  localparam int OutDataW = 16;

  // configuration register indexes
  localparam logic CFG_TIMEOUT_MS = 1'b0;
  localparam logic CFG_MIN_POLLS = 1'b1;

  // verdict codes
  localparam logic [1:0] VERDICT_CONT = 2'd0;
  localparam logic [1:0] VERDICT_OK = 2'd1;
  localparam logic [1:0] VERDICT_FAIL = 2'd2;

  // fail causes
  localparam logic [1:0] CAUSE_NONE = 2'd0;
  localparam logic [1:0] CAUSE_STUCK = 2'd1;
  localparam logic [1:0] CAUSE_TIMEOUT = 2'd2;

  // main relay commands
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_OPEN = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;

  typedef struct packed {
    logic [31:0] now_ms;
    logic test_status;
    logic safety_closed;
    logic restart;
  } poll_t;

  typedef struct packed {
    logic volt_test_line;
    logic outer_test_line;
    logic base_test_line;
    logic [1:0] main_relay_cmd;
    logic [1:0] fail_cause;
    logic [1:0] verdict;
  } result_t;

endpackage

// ===== hdl/rsts_core.sv =====
// test sequencer state and the per-poll decision logic
module rsts_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  rsts_pkg::poll_t                      poll,
  input  logic [rsts_pkg::TimeoutW-1:0]        timeout_ms,
  input  logic [rsts_pkg::MinPollsW-1:0]       min_polls,
  output rsts_pkg::result_t                    result
);
  import rsts_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE       = 4'd0,
    ST_INIT_MAIN  = 4'd1,
    ST_MAIN       = 4'd2,
    ST_INIT_BASE  = 4'd3,
    ST_BASE       = 4'd4,
    ST_INIT_OUTER = 4'd5,
    ST_OUTER      = 4'd6,
    ST_INIT_VOLT  = 4'd7,
    ST_VOLT       = 4'd8,
    ST_DONE       = 4'd9
  } step_t;

  typedef enum logic [1:0] {
    WT_NONE  = 2'd0,
    WT_CLOSE = 2'd1,
    WT_OPEN  = 2'd2
  } wait_t;

  step_t       step_r, step_nxt;
  wait_t       wait_r, wait_nxt;
  logic [7:0]  poll_r, poll_nxt, poll_sat;
  logic [31:0] start_r, start_nxt, elapsed;
  logic        base_r, base_nxt;
  logic        outer_r, outer_nxt;
  logic        volt_r, volt_nxt;
  logic        advance;
  logic        waiting;

  assign elapsed = poll.now_ms - start_r;
  assign waiting = (wait_r == WT_CLOSE) || (wait_r == WT_OPEN);
  assign poll_sat = (poll_r == 8'hFF) ? poll_r : poll_r + 8'd1;

  // next state and result of one poll
  always_comb begin
    step_nxt  = step_r;
    wait_nxt  = wait_r;
    poll_nxt  = poll_r;
    start_nxt = start_r;
    base_nxt  = base_r;
    outer_nxt = outer_r;
    volt_nxt  = volt_r;
    advance   = 1'b0;
    result.verdict = VERDICT_CONT;
    result.fail_cause = CAUSE_NONE;
    result.main_relay_cmd = CMD_NONE;

    if (poll.restart) begin
      poll_nxt  = '0;
      start_nxt = '0;
      step_nxt  = ST_IDLE;
      wait_nxt  = WT_NONE;
      base_nxt  = 1'b0;
      outer_nxt = 1'b0;
      volt_nxt  = 1'b0;
    end else if (poll.safety_closed) begin
      step_nxt  = ST_IDLE;
      wait_nxt  = WT_NONE;
      base_nxt  = 1'b0;
      outer_nxt = 1'b0;
      volt_nxt  = 1'b0;
      result.verdict = VERDICT_FAIL;
      result.fail_cause = CAUSE_STUCK;
    end else begin
      advance = 1'b1;
      // relay wait: timeout check, then status check
      if (waiting) begin
        poll_nxt = poll_sat;
        if ((elapsed > {16'h0000, timeout_ms}) && (poll_sat > min_polls)) begin
          advance   = 1'b0;
          step_nxt  = ST_IDLE;
          wait_nxt  = WT_NONE;
          base_nxt  = 1'b0;
          outer_nxt = 1'b0;
          volt_nxt  = 1'b0;
          result.verdict = VERDICT_FAIL;
          result.fail_cause = CAUSE_TIMEOUT;
        end else if ((wait_r == WT_OPEN && poll.test_status) ||
                     (wait_r == WT_CLOSE && !poll.test_status)) begin
          advance = 1'b0;
        end
      end
      // issue the next command of the sequence
      if (advance) begin
        poll_nxt  = '0;
        start_nxt = poll.now_ms;
        case (step_r)
          ST_INIT_MAIN: begin
            result.main_relay_cmd = CMD_OPEN;
            wait_nxt = WT_OPEN;
            step_nxt = ST_MAIN;
          end
          ST_MAIN: begin
            result.main_relay_cmd = CMD_CLOSE;
            wait_nxt = WT_CLOSE;
            step_nxt = ST_INIT_BASE;
          end
          ST_INIT_BASE: begin
            base_nxt = 1'b1;
            wait_nxt = WT_OPEN;
            step_nxt = ST_BASE;
          end
          ST_BASE: begin
            base_nxt = 1'b0;
            wait_nxt = WT_CLOSE;
            step_nxt = ST_INIT_OUTER;
          end
          ST_INIT_OUTER: begin
            outer_nxt = 1'b1;
            wait_nxt  = WT_OPEN;
            step_nxt  = ST_OUTER;
          end
          ST_OUTER: begin
            outer_nxt = 1'b0;
            wait_nxt  = WT_CLOSE;
            step_nxt  = ST_INIT_VOLT;
          end
          ST_INIT_VOLT: begin
            volt_nxt = 1'b1;
            wait_nxt = WT_OPEN;
            step_nxt = ST_VOLT;
          end
          ST_VOLT: begin
            volt_nxt = 1'b0;
            wait_nxt = WT_CLOSE;
            step_nxt = ST_DONE;
          end
          ST_DONE: begin
            wait_nxt = WT_NONE;
            step_nxt = ST_IDLE;
            result.verdict = VERDICT_OK;
          end
          default: begin
            wait_nxt = WT_CLOSE;
            step_nxt = ST_INIT_MAIN;
          end
        endcase
      end
    end

    result.base_test_line  = base_nxt;
    result.outer_test_line = outer_nxt;
    result.volt_test_line  = volt_nxt;
  end

  // state update on each poll that moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= ST_IDLE;
      wait_r  <= WT_NONE;
      poll_r  <= '0;
      start_r <= '0;
      base_r  <= 1'b0;
      outer_r <= 1'b0;
      volt_r  <= 1'b0;
    end else if (en) begin
      step_r  <= step_nxt;
      wait_r  <= wait_nxt;
      poll_r  <= poll_nxt;
      start_r <= start_nxt;
      base_r  <= base_nxt;
      outer_r <= outer_nxt;
      volt_r  <= volt_nxt;
    end
  end

endmodule

// ===== hdl/relay_self_test_sequencer_top.sv =====
// Relay self test sequencer: top level with input and result registers.
// A poll taken into the input register moves on to the result register when that is free.
// Throughput: one poll per cycle while out_tready holds; the sequencer state update is a single
// compare-and-subtract pass between the input register and result register.
// Reset (rst_n low, synchronous): test idle, drives low, timeout_ms 1000,
// min_polls 5, both pipeline registers empty.
module relay_self_test_sequencer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic                            cfg_idx,
  input  logic [rsts_pkg::CfgDataW-1:0]   cfg_wdata,
  // poll input
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // restart, safety_closed, test_status, now_ms[31:0], zero fill
  input  logic [rsts_pkg::InDataW-1:0]    in_tdata,
  // result output
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // verdict[1:0], fail_cause[1:0], main_relay_cmd[1:0], base_test_line,
  // outer_test_line, volt_test_line, zero fill
  output logic [rsts_pkg::OutDataW-1:0]   out_tdata
);
  import rsts_pkg::*;

  logic [TimeoutW-1:0]  timeout_r;
  logic [MinPollsW-1:0] min_polls_r;
  logic                 s1_valid_r;
  poll_t                s1_poll_r;
  logic                 out_valid_r;
  result_t              out_res_r;
  result_t              core_res;
  logic                 out_free;
  logic                 s1_fire;
  logic                 in_fire;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TimeoutW'(1000);
      min_polls_r <= MinPollsW'(5);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TIMEOUT_MS: timeout_r   <= cfg_wdata[TimeoutW-1:0];
        CFG_MIN_POLLS:  min_polls_r <= cfg_wdata[MinPollsW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_poll_r <= in_tdata[$bits(poll_t)-1:0];
    end
  end

  rsts_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (s1_fire),
    .poll       (s1_poll_r),
    .timeout_ms (timeout_r),
    .min_polls  (min_polls_r),
    .result     (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, out_res_r};

endmodule

// ===== hdl/rsts_checker.sv =====
// port-level checks of the relay self test sequencer, bound to the top level
`include "relay_self_test_sequencer_top_macros.svh"

module rsts_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [rsts_pkg::OutDataW-1:0] out_tdata
);
  import rsts_pkg::*;

  // a stalled result transaction holds
  `RSTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata))

  // a cause is reported only with a fail verdict
  `RSTS_ASSERT_NOW(a_cause_fail, clk, rst_n,
                   out_tvalid && out_tdata[1:0] != VERDICT_FAIL,
                   out_tdata[3:2] == CAUSE_NONE)

  // a relay command comes only on a continuing poll
  `RSTS_ASSERT_NOW(a_cmd_cont, clk, rst_n,
                   out_tvalid && out_tdata[5:4] != CMD_NONE,
                   out_tdata[1:0] == VERDICT_CONT)

  // a failed test leaves all test lines low
  `RSTS_ASSERT_NOW(a_fail_lines, clk, rst_n,
                   out_tvalid && out_tdata[1:0] == VERDICT_FAIL,
                   out_tdata[8:6] == 3'b000)

endmodule

bind relay_self_test_sequencer_top rsts_checker u_rsts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
